### rtl/gos_pkg.sv
// ----------------------------------------------------------------------------
// gos_pkg
// Shared types and constants of the three-axis gyro offset / smoothing block.
// ----------------------------------------------------------------------------
package gos_pkg;

  // Axis count and field widths
  localparam int unsigned NumAxes   = 3;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned RateW     = 24;
  localparam int unsigned SumW      = 33;
  localparam int unsigned CountW    = 16;
  localparam int unsigned WeightW   = 8;
  localparam int unsigned LimitW    = 15;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned KindW     = 2;

  // Filter weights are in 1/256 units; round half up before the shift
  localparam int unsigned WeightOne = 256;
  localparam int unsigned WeightSh  = 8;
  localparam int          RoundBias = 128;

  // Saturation bounds of a filtered rate
  localparam logic [RateW-1:0] RateMax = 24'h7F_FFFF;
  localparam logic [RateW-1:0] RateMin = 24'h80_0000;

  // One restoring step per quotient bit of the calibration sum
  localparam int unsigned DivSteps = SumW;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  // Register reset values
  localparam logic [WeightW-1:0] SmoothingRst = 8'd205;
  localparam logic [LimitW-1:0]  DeadbandRst  = 15'd66;
  localparam logic [LimitW-1:0]  ZLimitRst    = 15'd3275;
  localparam logic [LimitW-1:0]  XyLimitRst   = 15'd2620;
  localparam logic [CountW-1:0]  CalCountRst  = 16'd100;

  // Item kinds
  typedef enum logic [KindW-1:0] {
    KIND_START = 2'd0,
    KIND_CALIB = 2'd1,
    KIND_MEAS  = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SMOOTHING = 3'd0,
    CFG_DEADBAND  = 3'd1,
    CFG_Z_LIMIT   = 3'd2,
    CFG_XY_LIMIT  = 3'd3,
    CFG_CAL_COUNT = 3'd4
  } cfg_idx_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLR,
    ST_ACC,
    ST_DLD,
    ST_DIV,
    ST_MUL,
    ST_UPD,
    ST_OUT
  } state_e;

  // Per-cycle commands from the controller to every lane
  typedef struct packed {
    logic clr;       // clear calibration sum
    logic acc;       // add sample to calibration sum
    logic div_load;  // load divider from calibration sum
    logic div_step;  // one restoring division step
    logic div_last;  // final step: write offset
    logic mul;       // register filter products
    logic upd;       // update filter value
  } lane_ctl_t;

  // Filter settings shared by the lanes
  typedef struct packed {
    logic [WeightW-1:0] smoothing;
    logic [LimitW-1:0]  deadband;
  } lane_cfg_t;

endpackage

### rtl/gos_lane.sv
// ----------------------------------------------------------------------------
// gos_lane
// One axis: calibration sum, bit-serial offset divider, offset subtraction,
// exponential average with saturation and deadband.
// ----------------------------------------------------------------------------
module gos_lane
  import gos_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lane_ctl_t                 ctl_i,
  input  lane_cfg_t                 cfg_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic [CountW-1:0]         divisor_i,
  output logic signed [RateW-1:0]   rate_o
);

  localparam int unsigned PoldW = WeightW + 1 + RateW;
  localparam int unsigned PnewW = WeightW + 2 + SampleW;
  localparam int unsigned AccA  = PnewW + FRAC_BITS + 1;
  localparam int unsigned AccW  = (AccA > PoldW + 1) ? AccA : PoldW + 1;
  localparam int unsigned ShrW  = AccW - WeightSh;
  localparam int unsigned CmpA  = LimitW + FRAC_BITS;
  localparam int unsigned CmpW  = (CmpA > RateW) ? CmpA : RateW;

  logic signed [RateW-1:0]   filt_q, filt_d;
  logic signed [SampleW-1:0] off_q, off_d;
  logic signed [SumW-1:0]    sum_q, sum_d;
  logic signed [PoldW-1:0]   p_old_q, p_old_d;
  logic signed [PnewW-1:0]   p_new_q, p_new_d;
  logic [CountW-1:0]         rem_q, rem_d;
  logic [SumW-1:0]           dvd_q, dvd_d;
  logic                      neg_q, neg_d;

  // Divider step signals
  logic [CountW:0]           rem_sh;
  logic                      fits;
  logic [CountW-1:0]         rem_nx;
  logic [SumW-1:0]           dvd_nx;
  logic [SampleW-1:0]        quo;

  // Filter signals
  logic signed [SampleW-1:0] diff;
  logic [WeightW:0]          wt_new;
  logic signed [AccW-1:0]    acc;
  logic signed [ShrW-1:0]    shr;
  logic [ShrW-RateW:0]       hi;
  logic [RateW-1:0]          sat;
  logic [RateW-1:0]          mag;
  logic [CmpW-1:0]           db_lim;

  // Restoring division step on the magnitude of the sum
  always_comb begin
    rem_sh = {rem_q, dvd_q[SumW-1]};
    fits   = (rem_sh >= {1'b0, divisor_i});
    rem_nx = fits ? CountW'(rem_sh - {1'b0, divisor_i}) : rem_sh[CountW-1:0];
    dvd_nx = {dvd_q[SumW-2:0], fits};
    quo    = dvd_nx[SampleW-1:0];
  end

  // Form the two weighted products
  always_comb begin
    diff    = sample_i - off_q;
    wt_new  = (WeightW+1)'(WeightOne) - {1'b0, cfg_i.smoothing};
    p_old_d = $signed({1'b0, cfg_i.smoothing}) * filt_q;
    p_new_d = $signed({1'b0, wt_new}) * diff;
  end

  // Sum, round, shift, saturate and apply the deadband
  always_comb begin
    acc    = AccW'(p_old_q) + (AccW'(p_new_q) <<< FRAC_BITS) + AccW'(RoundBias);
    shr    = $signed(acc[AccW-1:WeightSh]);
    hi     = shr[ShrW-1:RateW-1];
    if ((&hi) || (~|hi)) begin
      sat = shr[RateW-1:0];
    end else begin
      sat = shr[ShrW-1] ? RateMin : RateMax;
    end
    mag    = sat[RateW-1] ? RateW'(-sat) : sat;
    db_lim = CmpW'(cfg_i.deadband) << FRAC_BITS;
  end

  // Next state of the lane registers
  always_comb begin
    filt_d = filt_q;
    off_d  = off_q;
    sum_d  = sum_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    neg_d  = neg_q;
    if (ctl_i.clr) begin
      sum_d = '0;
    end
    if (ctl_i.acc) begin
      sum_d = sum_q + SumW'(sample_i);
    end
    if (ctl_i.div_load) begin
      neg_d = sum_q[SumW-1];
      dvd_d = sum_q[SumW-1] ? SumW'(-sum_q) : sum_q;
      rem_d = '0;
    end
    if (ctl_i.div_step) begin
      rem_d = rem_nx;
      dvd_d = dvd_nx;
    end
    if (ctl_i.div_last) begin
      off_d = neg_q ? $signed(SampleW'(-quo)) : $signed(quo);
    end
    if (ctl_i.upd) begin
      filt_d = (CmpW'(mag) < db_lim) ? '0 : $signed(sat);
    end
  end

  // Hold lane state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
      off_q  <= '0;
      sum_q  <= '0;
    end else begin
      filt_q <= filt_d;
      off_q  <= off_d;
      sum_q  <= sum_d;
    end
  end

  // Hold products and divider datapath
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      p_old_q <= p_old_d;
      p_new_q <= p_new_d;
    end
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    neg_q <= neg_d;
  end

  assign rate_o = filt_q;

endmodule

### rtl/gos_merge.sv
// ----------------------------------------------------------------------------
// gos_merge
// Combine the lane rates with gesture flags and the calibration state into
// one result beat, held in the output register.
// ----------------------------------------------------------------------------
module gos_merge
  import gos_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic signed [RateW-1:0] rate_x_i,
  input  logic signed [RateW-1:0] rate_y_i,
  input  logic signed [RateW-1:0] rate_z_i,
  input  logic [LimitW-1:0]       z_limit_i,
  input  logic [LimitW-1:0]       xy_limit_i,
  input  logic                    calibrated_i,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [23:0] rate_x, [47:24] rate_y, [71:48] rate_z, [72] flag_x,
  // [73] flag_y, [74] flag_z, [75] calibrated, [79:76] zero
  output logic [79:0]             m_axis_tdata
);

  localparam int unsigned CmpA = LimitW + FRAC_BITS + 1;
  localparam int unsigned CmpW = (CmpA > RateW + 1) ? CmpA : RateW + 1;

  logic            valid_q, valid_d;
  logic [79:0]     data_q, data_d;
  logic [CmpW-1:0] xy_lim, z_lim;
  logic            flag_x, flag_y, flag_z;

  // Compare each rate against its scaled limit
  always_comb begin
    xy_lim = CmpW'(xy_limit_i) << FRAC_BITS;
    z_lim  = CmpW'(z_limit_i) << FRAC_BITS;
    flag_x = $signed(CmpW'(rate_x_i)) > $signed(xy_lim);
    flag_y = $signed(CmpW'(rate_y_i)) > $signed(xy_lim);
    flag_z = $signed(CmpW'(rate_z_i)) > $signed(z_lim);
  end

  // Pack the beat and track the output slot
  always_comb begin
    data_d  = load_i ? {4'd0, calibrated_i, flag_z, flag_y, flag_x,
                        rate_z_i, rate_y_i, rate_x_i} : data_q;
    valid_d = load_i | (valid_q & ~m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule

### rtl/gyro_offset_smooth_deadband_top.sv
// ----------------------------------------------------------------------------
// gyro_offset_smooth_deadband_top
// Three-axis gyro conditioner: offset calibration, smoothing, deadband and
// gesture flags, one lane per axis and a merge stage for the result beat.
// ----------------------------------------------------------------------------
// Flow: a measurement passes through the product and update states to the output
// state; start clears the sum and a counted calibration adds to it first; an
// ignored calibration or reserved kind goes straight to output; the beat that
// completes a calibration run first runs the 33 steps of the per-lane bit-serial
// offset divider. Input is taken only in idle; a stalled result slot holds it off.
// Reset: asynchronous, active low; config and state registers take defaults.
module gyro_offset_smooth_deadband_top
  import gos_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Sample stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] sample_x, [31:16] sample_y, [47:32] sample_z
  input  logic [47:0]         s_axis_tdata,
  // [1:0] kind
  input  logic [KindW-1:0]    s_axis_tuser,
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [23:0] rate_x, [47:24] rate_y, [71:48] rate_z, [72] flag_x,
  // [73] flag_y, [74] flag_z, [75] calibrated, [79:76] zero
  output logic [79:0]         m_axis_tdata
);

  // Configuration registers
  logic [WeightW-1:0] smoothing_q;
  logic [LimitW-1:0]  deadband_q, z_limit_q, xy_limit_q;
  logic [CountW-1:0]  cal_count_q;

  // Controller and calibration state
  state_e               state_q, state_d;
  logic [CountW-1:0]    seen_q, seen_d;
  logic                 done_q, done_d;
  logic [DivCntW-1:0]   div_cnt_q, div_cnt_d;
  logic [47:0]          samp_q;
  logic                 accept;
  logic [CountW-1:0]    seen_inc;
  logic                 cal_complete;
  logic                 div_last;
  logic                 out_load;
  lane_ctl_t            ctl;
  lane_cfg_t            lane_cfg;
  logic signed [RateW-1:0] rate [NumAxes];

  assign accept       = s_axis_tvalid & s_axis_tready;
  assign seen_inc     = seen_q + CountW'(1);
  assign cal_complete = (seen_inc >= cal_count_q) && (seen_inc != '0);
  assign div_last     = (div_cnt_q == DivCntW'(DivSteps - 1));

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smoothing_q <= SmoothingRst;
      deadband_q  <= DeadbandRst;
      z_limit_q   <= ZLimitRst;
      xy_limit_q  <= XyLimitRst;
      cal_count_q <= CalCountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SMOOTHING: smoothing_q <= cfg_data_i[WeightW-1:0];
        CFG_DEADBAND:  deadband_q  <= cfg_data_i[LimitW-1:0];
        CFG_Z_LIMIT:   z_limit_q   <= cfg_data_i[LimitW-1:0];
        CFG_XY_LIMIT:  xy_limit_q  <= cfg_data_i[LimitW-1:0];
        CFG_CAL_COUNT: cal_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_e'(s_axis_tuser))
            KIND_START: state_d = ST_CLR;
            KIND_CALIB: state_d = done_q ? ST_OUT : ST_ACC;
            KIND_MEAS:  state_d = ST_MUL;
            KIND_RSVD:  state_d = ST_OUT;
            default:    state_d = ST_OUT;
          endcase
        end
      end
      ST_CLR:  state_d = ST_OUT;
      ST_ACC:  state_d = cal_complete ? ST_DLD : ST_OUT;
      ST_DLD:  state_d = ST_DIV;
      ST_DIV:  state_d = div_last ? ST_OUT : ST_DIV;
      ST_MUL:  state_d = ST_UPD;
      ST_UPD:  state_d = ST_OUT;
      ST_OUT:  state_d = (!m_axis_tvalid || m_axis_tready) ? ST_IDLE : ST_OUT;
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    ctl           = '0;
    out_load      = 1'b0;
    s_axis_tready = 1'b0;
    seen_d        = seen_q;
    done_d        = done_q;
    div_cnt_d     = div_cnt_q;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_CLR: begin
        ctl.clr = 1'b1;
        seen_d  = '0;
        done_d  = 1'b0;
      end
      ST_ACC: begin
        ctl.acc = 1'b1;
        seen_d  = seen_inc;
      end
      ST_DLD: begin
        ctl.div_load = 1'b1;
        div_cnt_d    = '0;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        ctl.div_last = div_last;
        div_cnt_d    = div_cnt_q + DivCntW'(1);
        if (div_last) begin
          done_d = 1'b1;
        end
      end
      ST_MUL: ctl.mul = 1'b1;
      ST_UPD: ctl.upd = 1'b1;
      ST_OUT: out_load = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  // Hold controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      seen_q    <= '0;
      done_q    <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      seen_q    <= seen_d;
      done_q    <= done_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  // Capture the accepted samples
  always_ff @(posedge clk_i) begin
    if (accept) begin
      samp_q <= s_axis_tdata;
    end
  end

  assign lane_cfg.smoothing = smoothing_q;
  assign lane_cfg.deadband  = deadband_q;

  // One lane per axis
  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    gos_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .cfg_i     (lane_cfg),
      .sample_i  ($signed(samp_q[a*SampleW +: SampleW])),
      .divisor_i (seen_q),
      .rate_o    (rate[a])
    );
  end

  // Merge lanes into the result beat
  gos_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (out_load),
    .rate_x_i      (rate[0]),
    .rate_y_i      (rate[1]),
    .rate_z_i      (rate[2]),
    .z_limit_i     (z_limit_q),
    .xy_limit_i    (xy_limit_q),
    .calibrated_i  (done_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // A stalled result slot keeps the controller waiting
  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && m_axis_tvalid && !m_axis_tready) |=> (state_q == ST_OUT))
    else $error("result overwritten while stalled");

  // The divider never runs past its step count
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_cnt_q < DivCntW'(DivSteps)))
    else $error("divider step count overrun");

  // Calibration is only marked done by the last divider step
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> ($past(state_q) == ST_DIV && $past(div_last)))
    else $error("calibrated set outside divider completion");

endmodule
